// File: hdl/ttlc_pkg.sv
// Shared types and constants for the tile texture layer cache.
// Used by ttlc_ctrl, ttlc_datapath and tile_texture_layer_cache.
package ttlc_pkg;

	localparam int LAYER_W = 11;
	localparam int ZOOM_W  = 5;
	localparam int COORD_W = 32;
	localparam int STAT_W  = 3;

	// request function codes
	localparam logic FUNC_LOOKUP = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	// 2-bit signed entry score: live at 0 or 1, free at -1
	localparam logic [1:0] SCORE_FREE = 2'b11;
	localparam logic [1:0] SCORE_ZERO = 2'b00;
	localparam logic [1:0] SCORE_ONE  = 2'b01;

	typedef enum logic [STAT_W-1:0] {
		STAT_HIT       = 3'd0,
		STAT_PLACED    = 3'd1,
		STAT_NO_FREE   = 3'd2,
		STAT_EXHAUSTED = 3'd3,
		STAT_TICK      = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_PLACE,
		S_OUT
	} state_t;

	// one table entry as held in the entry memory
	typedef struct packed {
		logic [1:0]         score;
		logic               has_layer;
		logic [LAYER_W-1:0] layer;
		logic [ZOOM_W-1:0]  zoom;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic clear_wr;
		logic load_req;
		logic scan;
		logic place;
		logic out_load;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic scan_done;
		logic miss;
		logic out_free;
	} dp_stat_t;

endpackage

// File: hdl/ttlc_ctrl.sv
// Sequencing state machine of the tile texture layer cache.
// Depends on ttlc_pkg; drives ttlc_datapath through command and status structs.
module ttlc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ttlc_pkg::dp_stat_t   stat,
	output ttlc_pkg::ctrl_cmd_t  cmd
);
	import ttlc_pkg::*;

	state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clear_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_nxt = S_SCAN;
			end
			S_SCAN: begin
				if (stat.scan_done) state_nxt = stat.miss ? S_PLACE : S_OUT;
			end
			S_PLACE: begin
				state_nxt = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_CLEAR;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: cmd.clear_wr = 1'b1;
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
			end
			S_SCAN:  cmd.scan  = 1'b1;
			S_PLACE: cmd.place = 1'b1;
			S_OUT:   cmd.out_load = stat.out_free;
			default: cmd = '0;
		endcase
	end

`ifndef NO_ASSERTIONS
	// a result is only moved into a free output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded over a pending one");

	// placement only follows a scan that ended without a hit
	a_place_after_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE) |-> ($past(state_q) == S_SCAN && $past(stat.miss)))
		else $error("placement without a missed scan");

	// an accepted request always starts a scan
	a_req_scans: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_req |=> (state_q == S_SCAN))
		else $error("accepted request did not start a scan");
`endif

endmodule

// File: hdl/ttlc_datapath.sv
// Entry memory, scan pipeline, layer allocator and result registers.
// Depends on ttlc_pkg; sequenced by ttlc_ctrl.
module ttlc_datapath #(
	parameter int NUM_ENTRIES = 512,
	parameter int NUM_LAYERS  = 2048
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ttlc_pkg::ctrl_cmd_t                cmd,
	output ttlc_pkg::dp_stat_t                 stat,
	input  logic                               func,
	input  logic [ttlc_pkg::ZOOM_W-1:0]        zoom,
	input  logic [ttlc_pkg::COORD_W-1:0]       tile_x,
	input  logic [ttlc_pkg::COORD_W-1:0]       tile_y,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ttlc_pkg::LAYER_W-1:0]       layer,
	output logic [ttlc_pkg::STAT_W-1:0]        status
);
	import ttlc_pkg::*;

	localparam int ADDR_W = $clog2(NUM_ENTRIES);
	localparam int LCW    = $clog2(NUM_LAYERS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_ENTRIES - 1);

	entry_t mem [NUM_ENTRIES];

	// request registers
	logic               req_func_q;
	logic [ZOOM_W-1:0]  req_zoom_q;
	logic [COORD_W-1:0] req_col_q;
	logic [COORD_W-1:0] req_row_q;

	// scan control
	logic [ADDR_W-1:0]  addr_q;
	logic               rd_done_q;
	logic               rd_vld_s1;
	logic [ADDR_W-1:0]  idx_s1;
	entry_t             rd_data_s1;

	// first free entry seen in the scan
	logic               free_found_q;
	logic [ADDR_W-1:0]  free_idx_q;
	logic               free_has_q;
	logic [LAYER_W-1:0] free_layer_q;

	logic [LCW-1:0]     next_layer_q;
	logic [LAYER_W-1:0] res_layer_q;
	status_t            res_status_q;
	logic               out_valid_q;
	logic [LAYER_W-1:0] out_layer_q;
	status_t            out_status_q;

	logic               eval;
	logic               live;
	logic               hit;
	logic               can_alloc;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	entry_t             wr_data;
	logic [LAYER_W-1:0] place_layer;

	assign eval  = cmd.scan && rd_vld_s1;
	assign live  = !rd_data_s1.score[1];
	assign hit   = eval && (req_func_q == FUNC_LOOKUP) && live &&
		rd_data_s1.col == req_col_q && rd_data_s1.row == req_row_q &&
		rd_data_s1.zoom == req_zoom_q;
	assign can_alloc = (({1'b0, next_layer_q} + (LCW+1)'(1)) < (LCW+1)'(NUM_LAYERS));
	assign place_layer = free_has_q ? free_layer_q : LAYER_W'(next_layer_q);

	assign stat.clear_last = (addr_q == LAST_ADDR);
	assign stat.scan_done  = eval && (hit || idx_s1 == LAST_ADDR);
	assign stat.miss       = stat.scan_done && !hit && (req_func_q == FUNC_LOOKUP);
	assign stat.out_free   = !out_valid_q || out_ready;

	// write port select
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = rd_data_s1;
		if (cmd.clear_wr) begin
			wr_en         = 1'b1;
			wr_addr       = addr_q;
			wr_data       = '0;
			wr_data.score = SCORE_FREE;
		end else if (eval && req_func_q == FUNC_TICK) begin
			wr_en = 1'b1;
			case (rd_data_s1.score)
				SCORE_ONE:  wr_data.score = SCORE_ZERO;
				default:    wr_data.score = SCORE_FREE;
			endcase
		end else if (hit) begin
			wr_en         = 1'b1;
			wr_data.score = SCORE_ONE;
		end else if (cmd.place && free_found_q && (free_has_q || can_alloc)) begin
			wr_en             = 1'b1;
			wr_addr           = free_idx_q;
			wr_data.score     = SCORE_ONE;
			wr_data.has_layer = 1'b1;
			wr_data.layer     = place_layer;
			wr_data.zoom      = req_zoom_q;
			wr_data.col       = req_col_q;
			wr_data.row       = req_row_q;
		end
	end

	// entry memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_s1 <= mem[addr_q];
		idx_s1     <= addr_q;
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_func_q <= func;
			req_zoom_q <= zoom;
			req_col_q  <= tile_x;
			req_row_q  <= tile_y;
		end
	end

	// address counter and read pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			rd_done_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			if (cmd.clear_wr) begin
				addr_q <= stat.clear_last ? '0 : addr_q + 1'b1;
			end else if (cmd.load_req) begin
				addr_q    <= '0;
				rd_done_q <= 1'b0;
			end else if (cmd.scan && !rd_done_q) begin
				rd_vld_s1 <= 1'b1;
				if (addr_q == LAST_ADDR) rd_done_q <= 1'b1;
				else addr_q <= addr_q + 1'b1;
			end
		end
	end

	// first free entry tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_found_q <= 1'b0;
		end else if (cmd.load_req) begin
			free_found_q <= 1'b0;
		end else if (eval && !live && !free_found_q) begin
			free_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (eval && !live && !free_found_q) begin
			free_idx_q   <= idx_s1;
			free_has_q   <= rd_data_s1.has_layer;
			free_layer_q <= rd_data_s1.layer;
		end
	end

	// layer allocator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_layer_q <= '0;
		end else if (cmd.place && free_found_q && !free_has_q && can_alloc) begin
			next_layer_q <= next_layer_q + 1'b1;
		end
	end

	// result of the current request
	always_ff @(posedge clk) begin
		if (hit) begin
			res_layer_q  <= rd_data_s1.layer;
			res_status_q <= STAT_HIT;
		end else if (stat.scan_done && req_func_q == FUNC_TICK) begin
			res_layer_q  <= '0;
			res_status_q <= STAT_TICK;
		end else if (cmd.place) begin
			if (!free_found_q) begin
				res_layer_q  <= '0;
				res_status_q <= STAT_NO_FREE;
			end else if (free_has_q || can_alloc) begin
				res_layer_q  <= place_layer;
				res_status_q <= STAT_PLACED;
			end else begin
				res_layer_q  <= '0;
				res_status_q <= STAT_EXHAUSTED;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_layer_q  <= res_layer_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign layer     = out_layer_q;
	assign status    = out_status_q;

endmodule

// File: hdl/tile_texture_layer_cache.sv
// Top level of the tile texture layer cache.
// Depends on ttlc_pkg, ttlc_ctrl and ttlc_datapath.
//
// Maps a tile key (zoom, tile_x, tile_y) to a texture array layer.
// Input channel (in_valid/in_ready) carries func, zoom, tile_x, tile_y:
// func lookup searches the table, func tick ages every entry's score.
// Output channel (out_valid/out_ready) returns one layer/status per request:
// 0 hit, 1 placed (load the texture), 2 no free entry, 3 layers exhausted,
// 4 tick done.
// After reset a clearing pass writes all NUM_ENTRIES entries free, one per
// cycle; in_ready stays low until the pass ends.
// Each request walks the entry memory one entry per cycle through its single
// registered read port: a tick or a miss walks every entry and a miss then
// takes a placement step, while a hit ends the walk at the matching entry.
// One request is in work at a time; in_ready rises again as soon as the
// result sits in the output register, so the next request is taken while
// the previous result waits. If the receiver stalls with a result still held,
// the next finished result waits in the block until the register frees.
module tile_texture_layer_cache #(
	parameter int NUM_ENTRIES = 512,
	parameter int NUM_LAYERS  = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [ttlc_pkg::ZOOM_W-1:0]   zoom,
	input  logic [ttlc_pkg::COORD_W-1:0]  tile_x,
	input  logic [ttlc_pkg::COORD_W-1:0]  tile_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ttlc_pkg::LAYER_W-1:0]  layer,
	output logic [ttlc_pkg::STAT_W-1:0]   status
);
	import ttlc_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	ttlc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ttlc_datapath #(
		.NUM_ENTRIES (NUM_ENTRIES),
		.NUM_LAYERS  (NUM_LAYERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.func      (func),
		.zoom      (zoom),
		.tile_x    (tile_x),
		.tile_y    (tile_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.layer     (layer),
		.status    (status)
	);

endmodule

// File: tb/tile_texture_layer_cache_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for tile_texture_layer_cache: lookups and frame ticks in,
// layer/status out. Depends on ttlc_pkg and the tile_texture_layer_cache RTL.
module tile_texture_layer_cache_test;
	import ttlc_pkg::*;

	localparam int N_ENTRIES   = 512;
	localparam int N_LAYERS    = 2048;
	localparam int ITEM_BUDGET = 1300;
	// at most a full table walk per request, plus handshake slack, several times over
	localparam int CYCLE_LIMIT = ITEM_BUDGET * (N_ENTRIES + 64) * 3 + N_ENTRIES;

	typedef struct {
		logic [LAYER_W-1:0] layer;
		status_t            status;
	} tile_result_t;

	typedef struct packed {
		logic [ZOOM_W-1:0]  zoom;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} tile_key_t;

	// Mirror of the tile table; predicts one result per accepted request.
	class layer_cache_scoreboard;
		logic [1:0]         score[N_ENTRIES];
		bit                 has_layer[N_ENTRIES];
		logic [LAYER_W-1:0] slot_layer[N_ENTRIES];
		tile_key_t          slot_key[N_ENTRIES];
		logic [11:0]        next_layer;
		tile_result_t       expected_layers[$];
		int                 errors;
		int                 results_seen;

		function new();
			foreach (score[i]) begin
				score[i] = SCORE_FREE;
				has_layer[i] = 1'b0;
			end
			next_layer = '0;
			errors = 0;
			results_seen = 0;
		endfunction

		function int outstanding();
			return expected_layers.size();
		endfunction

		function void note_request(logic f, tile_key_t k);
			tile_result_t r;
			int free_slot;
			int i;
			free_slot = -1;
			r.layer = '0;
			// frame tick: age every live entry, free stays free
			if (f == FUNC_TICK) begin
				foreach (score[j]) begin
					if (score[j] == SCORE_ONE)
						score[j] = SCORE_ZERO;
					else if (score[j] == SCORE_ZERO)
						score[j] = SCORE_FREE;
				end
				r.status = STAT_TICK;
				expected_layers.push_back(r);
				return;
			end
			// scan in index order: first live match wins, remember first free slot
			for (i = 0; i < N_ENTRIES; i++) begin
				if (score[i] == SCORE_FREE) begin
					if (free_slot < 0)
						free_slot = i;
				end else if (slot_key[i] == k) begin
					score[i] = SCORE_ONE;
					r.layer = slot_layer[i];
					r.status = STAT_HIT;
					expected_layers.push_back(r);
					return;
				end
			end
			if (free_slot < 0) begin
				r.status = STAT_NO_FREE;
				expected_layers.push_back(r);
				return;
			end
			// a reused slot keeps its layer; a fresh one draws from the counter
			if (!has_layer[free_slot]) begin
				if (int'(next_layer) + 1 < N_LAYERS) begin
					slot_layer[free_slot] = next_layer[LAYER_W-1:0];
					has_layer[free_slot] = 1'b1;
					next_layer = next_layer + 12'd1;
				end else begin
					r.status = STAT_EXHAUSTED;
					expected_layers.push_back(r);
					return;
				end
			end
			score[free_slot] = SCORE_ONE;
			slot_key[free_slot] = k;
			r.layer = slot_layer[free_slot];
			r.status = STAT_PLACED;
			expected_layers.push_back(r);
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 50)
				$display("mismatch at result %0d: %s", results_seen, what);
		endtask

		task check_result(logic [LAYER_W-1:0] got_layer, logic [STAT_W-1:0] got_status);
			tile_result_t want;
			results_seen++;
			if (expected_layers.size() == 0) begin
				report_mismatch($sformatf("unexpected result layer %0d status %0d",
					got_layer, got_status));
				return;
			end
			want = expected_layers.pop_front();
			if (got_status !== want.status)
				report_mismatch($sformatf("status %0d, expected %s",
					got_status, want.status.name()));
			if (got_layer !== want.layer)
				report_mismatch($sformatf("layer %0d, expected %0d",
					got_layer, want.layer));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                func = FUNC_LOOKUP;
	logic [ZOOM_W-1:0]   zoom = '0;
	logic [COORD_W-1:0]  tile_x = '0;
	logic [COORD_W-1:0]  tile_y = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [LAYER_W-1:0]  layer;
	logic [STAT_W-1:0]   status;

	bit                  calm = 1'b0;
	int unsigned         cycle_count = 0;
	layer_cache_scoreboard board = new();

	tile_texture_layer_cache #(
		.NUM_ENTRIES(N_ENTRIES),
		.NUM_LAYERS (N_LAYERS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.zoom     (zoom),
		.tile_x   (tile_x),
		.tile_y   (tile_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.layer    (layer),
		.status   (status)
	);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: check on handshake, stall about one cycle in ten
	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_result(layer, status);
		out_ready <= calm || ($urandom_range(99) >= 10);
	end

	function automatic tile_key_t random_key();
		tile_key_t k;
		k.zoom = ZOOM_W'($urandom_range(31));
		k.col = $urandom;
		k.row = $urandom;
		return k;
	endfunction

	// same key with one bit of one field flipped
	function automatic tile_key_t nudge_key(tile_key_t k);
		case ($urandom_range(2))
			0: k.zoom = k.zoom ^ (5'd1 << $urandom_range(ZOOM_W - 1));
			1: k.col = k.col ^ (32'd1 << $urandom_range(COORD_W - 1));
			default: k.row = k.row ^ (32'd1 << $urandom_range(COORD_W - 1));
		endcase
		return k;
	endfunction

	function automatic tile_key_t make_key(logic [ZOOM_W-1:0] z, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y);
		tile_key_t k;
		k.zoom = z;
		k.col = x;
		k.row = y;
		return k;
	endfunction

	// hold the request until accepted, then maybe leave a gap
	task automatic issue_request(logic f, tile_key_t k);
		in_valid <= 1'b1;
		func <= f;
		zoom <= k.zoom;
		tile_x <= k.col;
		tile_y <= k.row;
		do @(posedge clk); while (!in_ready);
		board.note_request(f, k);
		if (!calm) begin
			while ($urandom_range(99) < 10) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	initial begin
		tile_key_t k;
		tile_key_t fill_keys[$];
		tile_key_t key_pool[$];
		int fresh;
		int pick;
		int n;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, partial key matches, aging, slot reuse
		issue_request(FUNC_LOOKUP, make_key(5'd0, 32'h0, 32'h0));
		issue_request(FUNC_LOOKUP, make_key(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		issue_request(FUNC_LOOKUP, make_key(5'd0, 32'h0, 32'h0));
		issue_request(FUNC_LOOKUP, make_key(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		issue_request(FUNC_LOOKUP, make_key(5'd1, 32'h0, 32'h0));
		issue_request(FUNC_LOOKUP, make_key(5'd0, 32'h1, 32'h0));
		issue_request(FUNC_LOOKUP, make_key(5'd0, 32'h0, 32'h1));
		issue_request(FUNC_LOOKUP, make_key(5'd16, 32'h8000_0000, 32'h0));
		issue_request(FUNC_LOOKUP, make_key(5'd0, 32'h0, 32'h8000_0000));
		// tick fields are don't-care
		issue_request(FUNC_TICK, make_key(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		// score 0 entry is still live
		issue_request(FUNC_LOOKUP, make_key(5'd0, 32'h0, 32'h0));
		issue_request(FUNC_TICK, make_key(5'd0, 32'h0, 32'h0));
		issue_request(FUNC_TICK, random_key());
		// everything free now; slots come back with their old layers
		issue_request(FUNC_LOOKUP, make_key(5'd5, 32'h1234_5678, 32'h9ABC_DEF0));
		issue_request(FUNC_LOOKUP, make_key(5'd0, 32'h0, 32'h0));
		issue_request(FUNC_LOOKUP, make_key(5'd5, 32'h1234_5678, 32'h9ABC_DEF0));
		issue_request(FUNC_TICK, random_key());

		// fill the whole table with fresh keys, then keep asking: table full
		issue_request(FUNC_TICK, random_key());
		issue_request(FUNC_TICK, random_key());
		fresh = 0;
		while (fresh < N_ENTRIES + 20) begin
			if (fill_keys.size() != 0 && $urandom_range(99) < 10) begin
				issue_request(FUNC_LOOKUP, fill_keys[$urandom_range(fill_keys.size() - 1)]);
			end else begin
				k = random_key();
				fill_keys.push_back(k);
				fresh++;
				issue_request(FUNC_LOOKUP, k);
			end
		end

		// mixed traffic over small key pools, with aging and near-miss keys
		for (n = 0; n < 560; n++) begin
			calm = (n >= 150 && n < 300);
			if (n % 70 == 0) begin
				key_pool.delete();
				repeat ($urandom_range(2, 48))
					key_pool.push_back(random_key());
			end
			pick = $urandom_range(99);
			if (pick < 12)
				issue_request(FUNC_TICK, random_key());
			else if (pick < 20)
				issue_request(FUNC_LOOKUP, random_key());
			else if (pick < 30)
				issue_request(FUNC_LOOKUP,
					nudge_key(key_pool[$urandom_range(key_pool.size() - 1)]));
			else
				issue_request(FUNC_LOOKUP, key_pool[$urandom_range(key_pool.size() - 1)]);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// drain, then watch for strays
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (N_ENTRIES + 16) @(posedge clk);
		if (board.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: sim.f
hdl/ttlc_pkg.sv
hdl/ttlc_ctrl.sv
hdl/ttlc_datapath.sv
hdl/tile_texture_layer_cache.sv
tb/tile_texture_layer_cache_test.sv
